// File: src/circle_rotated_rect_collision_defines.svh
// Assertion macros shared by the checker of circle_rotated_rect_collision.
// No dependencies; expects clk and arst_n in the scope of use.
`ifndef CIRCLE_ROTATED_RECT_COLLISION_DEFINES_SVH
`define CIRCLE_ROTATED_RECT_COLLISION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CRR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define CRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/crr_pkg.sv
// Shared widths, types and the sine table generator for the collision test.
// No dependencies.
package crr_pkg;

	localparam int COORD_W   = 20;              // signed coordinate
	localparam int LEN_W     = 19;              // unsigned length
	localparam int ANGLE_W   = 16;              // binary angle
	localparam int QFRAC_W   = 14;              // angle bits inside one quadrant
	localparam int TRIG_W    = 17;              // signed sin/cos, Q1.15 incl. +-1.0
	localparam int TRIG_FRAC = 15;
	localparam int DBL_W     = 22;              // doubled rectangle center
	localparam int DIFF_W    = 23;              // doubled offset circle - center
	localparam int PROD_W    = DIFF_W + TRIG_W; // trig * offset
	localparam int SUM_W     = PROD_W + 1;
	localparam int ROT_W     = SUM_W - TRIG_FRAC; // rotated offset after rounding
	localparam int MAG_W     = 25;              // distance to box edge, magnitude
	localparam int SQ_W      = 2 * MAG_W;
	localparam int DIST_W    = SQ_W + 1;
	localparam int RSQ_W     = 2 * LEN_W;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	typedef logic signed [TRIG_W-1:0] trig_t;

	// term * x^2 in Q30, truncating after each product
	function automatic logic [63:0] taylor_pow2(input logic [63:0] term, input logic [63:0] x);
		logic [63:0] t1;
		t1 = (term * x) >> 30;
		return (t1 * x) >> 30;
	endfunction

	// sin(x), x in Q30 radians, eight-term series, rounded half up to Q15
	function automatic logic [TRIG_W-1:0] sine_q15(input logic [63:0] x);
		logic [63:0]        t;
		logic signed [63:0] acc;
		logic [63:0]        q;
		t   = x;
		acc = $signed(x);
		t   = taylor_pow2(t, x) / 64'd6;
		acc = acc - $signed(t);
		t   = taylor_pow2(t, x) / 64'd20;
		acc = acc + $signed(t);
		t   = taylor_pow2(t, x) / 64'd42;
		acc = acc - $signed(t);
		t   = taylor_pow2(t, x) / 64'd72;
		acc = acc + $signed(t);
		t   = taylor_pow2(t, x) / 64'd110;
		acc = acc - $signed(t);
		t   = taylor_pow2(t, x) / 64'd156;
		acc = acc + $signed(t);
		t   = taylor_pow2(t, x) / 64'd210;
		acc = acc - $signed(t);
		if (acc < 0) begin
			acc = '0;
		end
		q = (64'(acc) + 64'd16384) >> 15;
		if (q > 64'd32768) begin
			q = 64'd32768;
		end
		return q[TRIG_W-1:0];
	endfunction

endpackage

// File: src/crr_sincos.sv
// Quarter-wave sine table and quadrant folding into signed sin/cos.
// Depends on crr_pkg.
module crr_sincos #(
	parameter int DEPTH = 256
) (
	input  logic [$clog2(DEPTH)-1:0] idx,
	input  crr_pkg::quad_t           quad,
	output crr_pkg::trig_t           sin_val,
	output crr_pkg::trig_t           cos_val
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [crr_pkg::TRIG_W-1:0] ROM_TOP = crr_pkg::sine_q15(crr_pkg::HALF_PI_Q30);

	logic [crr_pkg::TRIG_W-1:0] rom [DEPTH];
	logic [crr_pkg::TRIG_W-1:0] near_val;
	logic [crr_pkg::TRIG_W-1:0] far_val;

	for (genvar g = 0; g < DEPTH; g++) begin : g_rom
		localparam logic [63:0] ARG = (64'(g) * crr_pkg::HALF_PI_Q30) / 64'(DEPTH);
		assign rom[g] = crr_pkg::sine_q15(ARG);
	end

	// the far entry sits at DEPTH - idx; idx of zero hits the top entry
	assign near_val = rom[idx];
	assign far_val  = (idx == '0) ? ROM_TOP : rom[IDX_W'(DEPTH) - idx];

	always_comb begin
		case (quad)
			crr_pkg::QUAD_0: begin
				sin_val = $signed(near_val);
				cos_val = $signed(far_val);
			end
			crr_pkg::QUAD_1: begin
				sin_val = $signed(far_val);
				cos_val = -$signed(near_val);
			end
			crr_pkg::QUAD_2: begin
				sin_val = -$signed(near_val);
				cos_val = -$signed(far_val);
			end
			default: begin
				sin_val = -$signed(far_val);
				cos_val = $signed(near_val);
			end
		endcase
	end

endmodule

// File: src/circle_rotated_rect_collision.sv
// Circle versus rotated rectangle overlap test, seven-stage pipeline.
// Depends on crr_pkg and crr_sincos.
//
// channel  dir  handshake                    payload
// pair     in   pair_valid / pair_stall      circle_x/y/radius, rect_x/y/width/height/angle
// result   out  result_valid / result_stall  hit
//
// One transaction per cycle while result_stall is low.
// Stages: offsets+angle index, table lookup, four rotation products, rounding,
// edge distances, squares, compare into the output register.
// Each stage holds its own valid and takes data when empty or when the next one moves,
// so bubbles are squeezed out under result_stall. arst_n clears only the valid bits.
module circle_rotated_rect_collision #(
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pair_valid,
	output logic                              pair_stall,
	input  logic signed [crr_pkg::COORD_W-1:0] circle_x,
	input  logic signed [crr_pkg::COORD_W-1:0] circle_y,
	input  logic [crr_pkg::LEN_W-1:0]          circle_radius,
	input  logic signed [crr_pkg::COORD_W-1:0] rect_x,
	input  logic signed [crr_pkg::COORD_W-1:0] rect_y,
	input  logic [crr_pkg::LEN_W-1:0]          rect_width,
	input  logic [crr_pkg::LEN_W-1:0]          rect_height,
	input  logic [crr_pkg::ANGLE_W-1:0]        rect_angle,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              hit
);

	localparam int NSTAGE  = 7;
	localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
	localparam int IMUL_W  = crr_pkg::QFRAC_W + IDX_W + 1;
	localparam logic [crr_pkg::SUM_W-1:0] HALF_LSB = crr_pkg::SUM_W'(1) << (crr_pkg::TRIG_FRAC - 1);

	// distance from rot to the interval [-half, half]
	function automatic logic [crr_pkg::MAG_W-1:0] edge_gap(
		input logic signed [crr_pkg::ROT_W-1:0] rot,
		input logic [crr_pkg::LEN_W-1:0]        half
	);
		logic signed [crr_pkg::ROT_W-1:0] hs;
		logic signed [crr_pkg::ROT_W-1:0] gap;
		hs = $signed(crr_pkg::ROT_W'(half));
		if (rot < -hs) begin
			gap = -hs - rot;
		end else if (rot > hs) begin
			gap = rot - hs;
		end else begin
			gap = '0;
		end
		return gap[crr_pkg::MAG_W-1:0];
	endfunction

	logic [NSTAGE-1:0] vld_q;
	logic [NSTAGE-1:0] adv;

	// stage 1 inputs
	logic [IMUL_W-1:0]                      idx_prod;
	logic signed [crr_pkg::DBL_W-1:0]       cen_x, cen_y;

	logic [IDX_W-1:0]                       idx_s1;
	crr_pkg::quad_t                         quad_s1;
	logic signed [crr_pkg::DIFF_W-1:0]      dx_s1, dy_s1;
	logic [crr_pkg::LEN_W-1:0]              w_s1, h_s1, r_s1;

	crr_pkg::trig_t                         sin_c, cos_c;
	crr_pkg::trig_t                         sin_s2, cos_s2;
	logic signed [crr_pkg::DIFF_W-1:0]      dx_s2, dy_s2;
	logic [crr_pkg::LEN_W-1:0]              w_s2, h_s2;
	logic [crr_pkg::RSQ_W-1:0]              rsq_s2;

	logic signed [crr_pkg::PROD_W-1:0]      pcx_s3, psy_s3, psx_s3, pcy_s3;
	logic [crr_pkg::LEN_W-1:0]              w_s3, h_s3;
	logic [crr_pkg::RSQ_W-1:0]              rsq_s3;

	logic signed [crr_pkg::SUM_W-1:0]       sum_x, sum_y;
	logic signed [crr_pkg::ROT_W-1:0]       rot_x_s4, rot_y_s4;
	logic [crr_pkg::LEN_W-1:0]              w_s4, h_s4;
	logic [crr_pkg::RSQ_W-1:0]              rsq_s4;

	logic [crr_pkg::MAG_W-1:0]              gx_s5, gy_s5;
	logic [crr_pkg::RSQ_W-1:0]              rsq_s5;

	logic [crr_pkg::SQ_W-1:0]               sqx_s6, sqy_s6;
	logic [crr_pkg::RSQ_W-1:0]              rsq_s6;

	logic                                   hit_s7;

	// pipeline flow control
	always_comb begin
		adv[NSTAGE-1] = !vld_q[NSTAGE-1] || !result_stall;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= pair_valid;
			end
			for (int k = 1; k < NSTAGE; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign pair_stall   = !adv[0];
	assign result_valid = vld_q[NSTAGE-1];
	assign hit          = hit_s7;

	// stage 1: doubled center and offset, table index
	assign idx_prod = IMUL_W'(rect_angle[crr_pkg::QFRAC_W-1:0]) * IMUL_W'(SINE_TABLE_DEPTH);
	assign cen_x    = (crr_pkg::DBL_W'(rect_x) <<< 1) + crr_pkg::DBL_W'(rect_width);
	assign cen_y    = (crr_pkg::DBL_W'(rect_y) <<< 1) + crr_pkg::DBL_W'(rect_height);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			idx_s1  <= idx_prod[crr_pkg::QFRAC_W +: IDX_W];
			quad_s1 <= crr_pkg::quad_t'(rect_angle[crr_pkg::ANGLE_W-1 -: 2]);
			dx_s1   <= (crr_pkg::DIFF_W'(circle_x) <<< 1) - crr_pkg::DIFF_W'(cen_x);
			dy_s1   <= (crr_pkg::DIFF_W'(circle_y) <<< 1) - crr_pkg::DIFF_W'(cen_y);
			w_s1    <= rect_width;
			h_s1    <= rect_height;
			r_s1    <= circle_radius;
		end
	end

	// stage 2: sin/cos lookup, radius squared
	crr_sincos #(
		.DEPTH(SINE_TABLE_DEPTH)
	) u_sincos (
		.idx     (idx_s1),
		.quad    (quad_s1),
		.sin_val (sin_c),
		.cos_val (cos_c)
	);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sin_s2 <= sin_c;
			cos_s2 <= cos_c;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			w_s2   <= w_s1;
			h_s2   <= h_s1;
			rsq_s2 <= crr_pkg::RSQ_W'(r_s1) * crr_pkg::RSQ_W'(r_s1);
		end
	end

	// stage 3: rotation products
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			pcx_s3 <= crr_pkg::PROD_W'(cos_s2) * crr_pkg::PROD_W'(dx_s2);
			psy_s3 <= crr_pkg::PROD_W'(sin_s2) * crr_pkg::PROD_W'(dy_s2);
			psx_s3 <= crr_pkg::PROD_W'(sin_s2) * crr_pkg::PROD_W'(dx_s2);
			pcy_s3 <= crr_pkg::PROD_W'(cos_s2) * crr_pkg::PROD_W'(dy_s2);
			w_s3   <= w_s2;
			h_s3   <= h_s2;
			rsq_s3 <= rsq_s2;
		end
	end

	// stage 4: sum and round half up back to the doubled grid (floor on the upper bits)
	assign sum_x = crr_pkg::SUM_W'(pcx_s3) - crr_pkg::SUM_W'(psy_s3) + $signed(HALF_LSB);
	assign sum_y = crr_pkg::SUM_W'(psx_s3) + crr_pkg::SUM_W'(pcy_s3) + $signed(HALF_LSB);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			rot_x_s4 <= sum_x[crr_pkg::SUM_W-1:crr_pkg::TRIG_FRAC];
			rot_y_s4 <= sum_y[crr_pkg::SUM_W-1:crr_pkg::TRIG_FRAC];
			w_s4     <= w_s3;
			h_s4     <= h_s3;
			rsq_s4   <= rsq_s3;
		end
	end

	// stage 5: clamp against the box, relative to its center (doubled half size = w, h)
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			gx_s5  <= edge_gap(rot_x_s4, w_s4);
			gy_s5  <= edge_gap(rot_y_s4, h_s4);
			rsq_s5 <= rsq_s4;
		end
	end

	// stage 6: squares
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			sqx_s6 <= crr_pkg::SQ_W'(gx_s5) * crr_pkg::SQ_W'(gx_s5);
			sqy_s6 <= crr_pkg::SQ_W'(gy_s5) * crr_pkg::SQ_W'(gy_s5);
			rsq_s6 <= rsq_s5;
		end
	end

	// stage 7: compare against (2r)^2
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			hit_s7 <= (crr_pkg::DIST_W'(sqx_s6) + crr_pkg::DIST_W'(sqy_s6))
				< crr_pkg::DIST_W'({rsq_s6, 2'b00});
		end
	end

endmodule

// File: src/crr_checker.sv
// Port-level checker for circle_rotated_rect_collision, bound to the top level.
// Depends on circle_rotated_rect_collision_defines.svh.
`include "circle_rotated_rect_collision_defines.svh"

module crr_checker (
	input logic clk,
	input logic arst_n,
	input logic pair_valid,
	input logic pair_stall,
	input logic result_valid,
	input logic result_stall,
	input logic hit
);

	`CRR_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid, "result dropped while stalled")
	`CRR_ASSERT_NEXT(a_hit_held, result_valid && result_stall, $stable(hit), "hit changed while stalled")
	// a free output slot frees the whole pipe
	`CRR_ASSERT_NOW(a_room, !result_valid || !result_stall, !pair_stall, "input stalled with output free")
	// an accepted transaction reaches the output while result_stall stays low behind it
	`CRR_ASSERT_NEXT(a_latency, (pair_valid && !pair_stall) ##1 !result_stall ##1 !result_stall ##1 !result_stall ##1 !result_stall ##1 !result_stall ##1 !result_stall, result_valid, "transaction not delivered in seven cycles")

endmodule

bind circle_rotated_rect_collision crr_checker u_crr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pair_valid   (pair_valid),
	.pair_stall   (pair_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.hit          (hit)
);

// File: bench/crr_checker.sv
`timescale 1ns / 100ps
// Scoreboard for circle_rotated_rect_collision: predicts the hit flag of every accepted pair
// and compares it with every accepted result. Depends on crr_pkg.
module crr_scoreboard #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pair_valid,
	input  logic                               pair_stall,
	input  logic signed [crr_pkg::COORD_W-1:0] circle_x,
	input  logic signed [crr_pkg::COORD_W-1:0] circle_y,
	input  logic [crr_pkg::LEN_W-1:0]          circle_radius,
	input  logic signed [crr_pkg::COORD_W-1:0] rect_x,
	input  logic signed [crr_pkg::COORD_W-1:0] rect_y,
	input  logic [crr_pkg::LEN_W-1:0]          rect_width,
	input  logic [crr_pkg::LEN_W-1:0]          rect_height,
	input  logic [crr_pkg::ANGLE_W-1:0]        rect_angle,
	input  logic                               result_valid,
	input  logic                               result_stall,
	input  logic                               hit,
	output int                                 mismatches,
	output int                                 outstanding
);

	longint sine_rom [0:TABLE_DEPTH];   // Q1.15 quarter wave, index 0..DEPTH
	bit     hit_expected_q [$];
	bit     want_hit;
	int     err_cnt;

	// quarter-wave table: Q30 Taylor series, eight terms, rounded half up to Q15
	initial begin
		longint unsigned x, term, q;
		longint          acc;
		for (int i = 0; i <= TABLE_DEPTH; i++) begin
			x    = (longint'(i) * crr_pkg::HALF_PI_Q30) / TABLE_DEPTH;
			term = x;
			acc  = x;
			for (longint unsigned k = 1; k <= 7; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / ((2 * k) * (2 * k + 1));
				if (k[0]) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			q = (longint'(acc) + 16384) >> 15;
			if (q > 32768) begin
				q = 32768;
			end
			sine_rom[i] = q;
		end
	end

	// floor((t + 2^14) / 2^15)
	function automatic longint round_q15(input longint t);
		return (t + 64'sd16384) >>> 15;
	endfunction

	function automatic longint clamp_span(input longint v, input longint lo, input longint hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// all lengths doubled so the rectangle center stays exact
	function automatic bit overlaps(
		input logic signed [crr_pkg::COORD_W-1:0] cx,
		input logic signed [crr_pkg::COORD_W-1:0] cy,
		input logic [crr_pkg::LEN_W-1:0]          rad,
		input logic signed [crr_pkg::COORD_W-1:0] rx,
		input logic signed [crr_pkg::COORD_W-1:0] ry,
		input logic [crr_pkg::LEN_W-1:0]          w,
		input logic [crr_pkg::LEN_W-1:0]          hgt,
		input logic [crr_pkg::ANGLE_W-1:0]        ang
	);
		longint          px, py, r, bx, by, bw, bh, s, c;
		longint          mid_x2, mid_y2, off_x2, off_y2, rot_x2, rot_y2, ex, ey;
		int unsigned     idx;
		crr_pkg::quad_t  quad;
		px   = cx;
		py   = cy;
		r    = rad;
		bx   = rx;
		by   = ry;
		bw   = w;
		bh   = hgt;
		idx  = (32'(ang[crr_pkg::QFRAC_W-1:0]) * TABLE_DEPTH) >> crr_pkg::QFRAC_W;
		quad = crr_pkg::quad_t'(ang[crr_pkg::ANGLE_W-1:crr_pkg::QFRAC_W]);
		case (quad)
			crr_pkg::QUAD_0: begin
				s = sine_rom[idx];
				c = sine_rom[TABLE_DEPTH - idx];
			end
			crr_pkg::QUAD_1: begin
				s = sine_rom[TABLE_DEPTH - idx];
				c = -sine_rom[idx];
			end
			crr_pkg::QUAD_2: begin
				s = -sine_rom[idx];
				c = -sine_rom[TABLE_DEPTH - idx];
			end
			default: begin
				s = -sine_rom[TABLE_DEPTH - idx];
				c = sine_rom[idx];
			end
		endcase
		mid_x2 = 2 * bx + bw;
		mid_y2 = 2 * by + bh;
		off_x2 = 2 * px - mid_x2;
		off_y2 = 2 * py - mid_y2;
		rot_x2 = round_q15(c * off_x2 - s * off_y2) + mid_x2;
		rot_y2 = round_q15(s * off_x2 + c * off_y2) + mid_y2;
		ex     = rot_x2 - clamp_span(rot_x2, 2 * bx, 2 * bx + 2 * bw);
		ey     = rot_y2 - clamp_span(rot_y2, 2 * by, 2 * by + 2 * bh);
		return (ex * ex + ey * ey) < (2 * r) * (2 * r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_expected_q.delete();
			err_cnt = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (hit_expected_q.size() == 0) begin
					err_cnt++;
					$error("hit: expected no transaction, actual %0b", hit);
				end else begin
					want_hit = hit_expected_q.pop_front();
					if (hit !== want_hit) begin
						err_cnt++;
						$error("hit: expected %0b, actual %0b", want_hit, hit);
					end
				end
			end
			if (pair_valid && !pair_stall) begin
				hit_expected_q.push_back(overlaps(circle_x, circle_y, circle_radius, rect_x,
					rect_y, rect_width, rect_height, rect_angle));
			end
			mismatches  <= err_cnt;
			outstanding <= hit_expected_q.size();
		end
	end

endmodule

// File: bench/tb_circle_rotated_rect_collision.sv
`timescale 1ns / 100ps
// Top of the circle_rotated_rect_collision testbench: clock, reset, pair stimulus,
// result back-pressure and the verdict. Depends on crr_pkg, the block and crr_scoreboard.
module tb_circle_rotated_rect_collision;

	localparam int DEPTH            = 256;
	localparam int RANDOM_PER_PHASE = 580;
	localparam int HOLD_CYCLES      = 80;
	localparam int TAIL_CYCLES      = 20;   // pipeline is seven deep

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               pair_valid;
	logic                               pair_stall;
	logic signed [crr_pkg::COORD_W-1:0] circle_x, circle_y, rect_x, rect_y;
	logic [crr_pkg::LEN_W-1:0]          circle_radius, rect_width, rect_height;
	logic [crr_pkg::ANGLE_W-1:0]        rect_angle;
	logic                               result_valid;
	logic                               result_stall;
	logic                               hit;

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	int mismatches;
	int outstanding;

	circle_rotated_rect_collision #(
		.SINE_TABLE_DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pair_valid   (pair_valid),
		.pair_stall   (pair_stall),
		.circle_x     (circle_x),
		.circle_y     (circle_y),
		.circle_radius(circle_radius),
		.rect_x       (rect_x),
		.rect_y       (rect_y),
		.rect_width   (rect_width),
		.rect_height  (rect_height),
		.rect_angle   (rect_angle),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.hit          (hit)
	);

	crr_scoreboard #(
		.TABLE_DEPTH(DEPTH)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.pair_valid   (pair_valid),
		.pair_stall   (pair_stall),
		.circle_x     (circle_x),
		.circle_y     (circle_y),
		.circle_radius(circle_radius),
		.rect_x       (rect_x),
		.rect_y       (rect_y),
		.rect_width   (rect_width),
		.rect_height  (rect_height),
		.rect_angle   (rect_angle),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.hit          (hit),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end

	// result side: random stall, or one long hold-off on request
	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// returns at the edge where the transaction is taken
	task automatic send_pair(
		input logic signed [crr_pkg::COORD_W-1:0] cx,
		input logic signed [crr_pkg::COORD_W-1:0] cy,
		input logic [crr_pkg::LEN_W-1:0]          rad,
		input logic signed [crr_pkg::COORD_W-1:0] rx,
		input logic signed [crr_pkg::COORD_W-1:0] ry,
		input logic [crr_pkg::LEN_W-1:0]          w,
		input logic [crr_pkg::LEN_W-1:0]          hgt,
		input logic [crr_pkg::ANGLE_W-1:0]        ang
	);
		while ($urandom_range(99) < send_idle_pct) begin
			pair_valid <= 1'b0;
			@(posedge clk);
		end
		pair_valid    <= 1'b1;
		circle_x      <= cx;
		circle_y      <= cy;
		circle_radius <= rad;
		rect_x        <= rx;
		rect_y        <= ry;
		rect_width    <= w;
		rect_height   <= hgt;
		rect_angle    <= ang;
		@(posedge clk);
		while (pair_stall) begin
			@(posedge clk);
		end
	endtask

	// mostly circles placed around the rectangle at a random scale, some raw noise
	task automatic send_random_pair();
		int                                 sc;
		logic signed [crr_pkg::COORD_W-1:0] rx, ry, cx, cy;
		logic [crr_pkg::LEN_W-1:0]          w, hgt, rad;
		if ($urandom_range(99) < 25) begin
			send_pair(crr_pkg::COORD_W'($urandom), crr_pkg::COORD_W'($urandom),
				crr_pkg::LEN_W'($urandom), crr_pkg::COORD_W'($urandom),
				crr_pkg::COORD_W'($urandom), crr_pkg::LEN_W'($urandom),
				crr_pkg::LEN_W'($urandom), crr_pkg::ANGLE_W'($urandom));
		end else begin
			sc  = 1 << $urandom_range(18, 2);
			rx  = crr_pkg::COORD_W'($urandom);
			ry  = crr_pkg::COORD_W'($urandom);
			w   = crr_pkg::LEN_W'($urandom_range(sc, 0));
			hgt = crr_pkg::LEN_W'($urandom_range(sc, 0));
			rad = crr_pkg::LEN_W'($urandom_range(sc, 0));
			cx  = crr_pkg::COORD_W'(int'(rx) + int'($urandom_range(4 * sc, 0)) - sc);
			cy  = crr_pkg::COORD_W'(int'(ry) + int'($urandom_range(4 * sc, 0)) - sc);
			send_pair(cx, cy, rad, rx, ry, w, hgt, crr_pkg::ANGLE_W'($urandom));
		end
	endtask

	// stop offering until every expected result is back
	task automatic drain();
		pair_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		pair_valid     <= 1'b0;
		circle_x       <= '0;
		circle_y       <= '0;
		circle_radius  <= '0;
		rect_x         <= '0;
		rect_y         <= '0;
		rect_width     <= '0;
		rect_height    <= '0;
		rect_angle     <= '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: degenerate shapes, quadrant edges, field extremes
		send_pair(0, 0, 0, 0, 0, 0, 0, 0);
		send_pair(80, 80, 0, 0, 0, 160, 160, 0);             // zero radius inside: no hit
		send_pair(80, 80, 16, 0, 0, 160, 160, 0);
		send_pair(80, 80, 16, 0, 0, 160, 160, 16383);
		send_pair(80, 80, 16, 0, 0, 160, 160, 16384);
		send_pair(80, 80, 16, 0, 0, 160, 160, 32768);
		send_pair(80, 80, 16, 0, 0, 160, 160, 49152);
		send_pair(80, 80, 16, 0, 0, 160, 160, 65535);
		send_pair(16, 0, 16, 0, 0, 0, 0, 0);                 // touching point: strict test
		send_pair(16, 0, 17, 0, 0, 0, 0, 0);
		send_pair(0, 40, 8, 0, 0, 0, 320, 8192);             // zero-width segment
		send_pair(300, 16, 8, 0, 0, 320, 32, 16384);         // long bar turned a quarter
		send_pair(300, 16, 8, 0, 0, 320, 32, 0);
		send_pair(-524288, 524287, 524287, 524287, -524288, 524287, 524287, 65535);
		send_pair(524287, 524287, 524287, 524287, 524287, 524287, 524287, 32767);
		send_pair(-524288, -524288, 0, -524288, -524288, 0, 0, 0);
		send_pair(-524288, -524288, 524287, 524287, 524287, 0, 0, 49151);
		send_pair(-1, -1, 524287, -1, -1, 524287, 524287, 65535);
		send_pair(-524288, 0, 1, 524287, 0, 524287, 1, 40000);
		send_pair(1000, -1000, 524287, -3000, 2000, 0, 524287, 24576);
		drain();

		send_idle_pct  = 11;
		recv_stall_pct = 58;
		repeat (RANDOM_PER_PHASE) send_random_pair();
		drain();

		send_idle_pct  = 58;
		recv_stall_pct = 11;
		repeat (RANDOM_PER_PHASE) send_random_pair();
		drain();

		// back to back while the result side holds off, so the pipe fills up
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b1;
		repeat (RANDOM_PER_PHASE) send_random_pair();
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
